FILE: hdl/crlc_pkg.sv
// Package for the content rating label checker: types, constants and helper functions.
package crlc_pkg;

    localparam int BYTE_W      = 8;
    localparam int VALUE_W     = 10;
    localparam int PREFIX_W    = 4;
    localparam int LEN_W       = 3;
    localparam int CFG_INDEX_W = 2;

    localparam logic [PREFIX_W-1:0] PREFIX_LEN = 4'd9;
    localparam logic [LEN_W-1:0]    AGE_LEN    = 3'd6;
    localparam logic [VALUE_W-1:0]  VALUE_MAX  = 10'd1023;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_AGE_LEVEL    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LETTER_LEVEL = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KIDS_LEVEL   = 2'd2;

    typedef enum logic [2:0] {
        TOK_FIRST,
        TOK_WORD,
        TOK_QUOTED,
        TOK_RATING_START,
        TOK_RATING,
        TOK_VALUE_START,
        TOK_VALUE,
        TOK_MULTI
    } tok_state_t;

    typedef enum logic [1:0] {
        PHASE_IDLE,
        PHASE_SKIP_WORD,
        PHASE_SKIP_SPACE,
        PHASE_DIGITS
    } phase_t;

    typedef enum logic [1:0] {
        VERDICT_NONE = 2'd0,
        VERDICT_OK   = 2'd1,
        VERDICT_WARN = 2'd2
    } verdict_t;

    // One bit per label kind; used for live candidates and for pending checks.
    typedef struct packed {
        logic kids;
        logic letter;
        logic age;
    } kind_set_t;

    localparam kind_set_t KIND_NONE = '{kids: 1'b0, letter: 1'b0, age: 1'b0};

    function automatic logic is_ws(input logic [BYTE_W-1:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic [BYTE_W-1:0] to_upper(input logic [BYTE_W-1:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function automatic logic [BYTE_W-1:0] lead_char(input logic [PREFIX_W-1:0] idx);
        logic [BYTE_W-1:0] ch;
        case (idx)
            4'd0:    ch = "(";
            4'd1:    ch = "P";
            4'd2:    ch = "I";
            4'd3:    ch = "C";
            4'd4:    ch = "S";
            4'd5:    ch = "-";
            4'd6:    ch = "1";
            4'd7:    ch = ".";
            4'd8:    ch = "1";
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

    function automatic logic [BYTE_W-1:0] age_char(input logic [LEN_W-1:0] idx);
        logic [BYTE_W-1:0] ch;
        case (idx)
            3'd0, 3'd1: ch = "S";
            3'd2, 3'd3: ch = "~";
            3'd4, 3'd5: ch = "0";
            default:    ch = 8'd0;
        endcase
        return ch;
    endfunction

    function automatic logic is_letter_label(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] u;
        u = to_upper(c);
        return (u == "N" || u == "S" || u == "V" || u == "L");
    endfunction

    function automatic logic is_kids_first(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] u;
        u = to_upper(c);
        return (u == "C" || u == "L" || u == "N" || u == "O" || u == "V");
    endfunction

    function automatic logic level_ok(input logic [VALUE_W-1:0] acc,
                                      input logic               neg,
                                      input logic [BYTE_W-1:0]  level);
        logic [VALUE_W-1:0] lv;
        lv = {{(VALUE_W-BYTE_W){1'b0}}, level};
        return neg ? (acc == '0 && level == '0) : (acc == lv);
    endfunction

    // True when any pending label disagrees with the parsed value.
    function automatic logic eval_warn(input kind_set_t          pend,
                                       input logic [VALUE_W-1:0] acc,
                                       input logic               neg,
                                       input logic [BYTE_W-1:0]  age_lv,
                                       input logic [BYTE_W-1:0]  letter_lv,
                                       input logic [BYTE_W-1:0]  kids_lv);
        return (pend.age    && !level_ok(acc, neg, age_lv))
            || (pend.letter && !level_ok(acc, neg, letter_lv))
            || (pend.kids   && !level_ok(acc, neg, kids_lv));
    endfunction

    // acc*10 + digit, saturated
    function automatic logic [VALUE_W-1:0] acc_digit(input logic [VALUE_W-1:0] acc,
                                                     input logic [BYTE_W-1:0]  c);
        logic [VALUE_W+3:0] v;
        v = {acc, 3'b000} + {2'b00, acc, 1'b0}
          + {{(VALUE_W){1'b0}}, c[3:0] - 4'd0};
        return (v > {4'b0000, VALUE_MAX}) ? VALUE_MAX : v[VALUE_W-1:0];
    endfunction

endpackage

FILE: hdl/content_rating_label_checker.sv
// Content rating label checker: header tokenizer, label matcher and value check.
//
//  channel   signals                              direction  moves
//  -------   -----------------------------------  ---------  --------------------------------
//  in        in_valid/in_ready, text_byte,        sink       one header byte per transaction
//            end_of_text
//  out       out_valid/out_ready, verdict         source     one verdict per finished header
//  cfg       cfg_write_en, cfg_index, cfg_data    sink       level register write, no wait
//
//  One byte per cycle while in_ready is high: each accepted byte updates the session
//  registers through one pass of logic (prefix match, value parser, label matcher,
//  tokenizer); the final byte loads the verdict register in the same cycle, and out_valid
//  is high in the cycle after. in_ready drops only while a verdict sits in the output
//  register and out_ready is low. Reset clears the session and returns the levels to 1, 0, 1.
module content_rating_label_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [crlc_pkg::BYTE_W-1:0]       text_byte,
    input  logic                              end_of_text,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        verdict,
    input  logic                              cfg_write_en,
    input  logic [crlc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [crlc_pkg::BYTE_W-1:0]       cfg_data
);
    import crlc_pkg::*;

    // Level registers
    logic [BYTE_W-1:0]   age_level_reg, letter_level_reg, kids_level_reg;

    // Session state
    logic [PREFIX_W-1:0] prefix_position_reg, prefix_position_next;
    logic                prefix_failed_reg, prefix_failed_next;
    tok_state_t          token_state_reg, token_state_next;
    logic [LEN_W-1:0]    label_length_reg, label_length_next;
    kind_set_t           cand_reg, cand_next;
    phase_t              check_phase_reg, check_phase_next;
    kind_set_t           pending_reg, pending_next;
    logic [VALUE_W-1:0]  value_acc_reg, value_acc_next;
    logic                value_neg_reg, value_neg_next;
    logic                warning_seen_reg, warning_seen_next;
    logic                text_stopped_reg, text_stopped_next;

    // Output stage
    logic                out_valid_reg, out_valid_next;
    verdict_t            verdict_reg, verdict_next;

    logic                in_fire;
    logic                ws;
    logic                digit;
    logic [LEN_W-1:0]    p;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;
    assign ws        = is_ws(text_byte);
    assign digit     = is_digit(text_byte);
    assign p         = label_length_reg;

    // Level registers take writes at any time; the block is idle by contract.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_level_reg    <= 8'd1;
            letter_level_reg <= 8'd0;
            kids_level_reg   <= 8'd1;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_AGE_LEVEL:    age_level_reg    <= cfg_data;
                CFG_LETTER_LEVEL: letter_level_reg <= cfg_data;
                CFG_KIDS_LEVEL:   kids_level_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        prefix_position_next = prefix_position_reg;
        prefix_failed_next   = prefix_failed_reg;
        token_state_next     = token_state_reg;
        label_length_next    = label_length_reg;
        cand_next            = cand_reg;
        check_phase_next     = check_phase_reg;
        pending_next         = pending_reg;
        value_acc_next       = value_acc_reg;
        value_neg_next       = value_neg_reg;
        warning_seen_next    = warning_seen_reg;
        text_stopped_next    = text_stopped_reg;
        out_valid_next       = out_valid_reg && !out_ready;
        verdict_next         = verdict_reg;

        if (in_fire)
        begin
            if (!text_stopped_reg && !prefix_failed_reg)
            begin
                if (prefix_position_reg < PREFIX_LEN)
                begin
                    // Case-blind prefix match; a zero byte fails it
                    if (text_byte == '0 || to_upper(text_byte) != lead_char(prefix_position_reg))
                        prefix_failed_next = 1'b1;
                    else
                        prefix_position_next = prefix_position_reg + 4'd1;
                end
                else if (text_byte == '0)
                begin
                    // Zero byte ends the text early
                    if ((cand_reg.age && label_length_reg == AGE_LEN)
                        || (check_phase_reg == PHASE_DIGITS
                            && eval_warn(pending_reg, value_acc_reg, value_neg_reg,
                                         age_level_reg, letter_level_reg, kids_level_reg)))
                        warning_seen_next = 1'b1;
                    cand_next         = KIND_NONE;
                    label_length_next = '0;
                    check_phase_next  = PHASE_IDLE;
                    pending_next      = KIND_NONE;
                    value_acc_next    = '0;
                    value_neg_next    = 1'b0;
                    text_stopped_next = 1'b1;
                end
                else
                begin
                    // Value parser
                    case (check_phase_reg)
                        PHASE_SKIP_WORD:
                        begin
                            if (ws)
                                check_phase_next = PHASE_SKIP_SPACE;
                        end
                        PHASE_SKIP_SPACE:
                        begin
                            if (ws)
                            begin
                            end
                            else if (text_byte == "+" || text_byte == "-")
                            begin
                                value_neg_next   = (text_byte == "-");
                                check_phase_next = PHASE_DIGITS;
                            end
                            else if (digit)
                            begin
                                value_acc_next   = {{(VALUE_W-4){1'b0}}, text_byte[3:0]};
                                check_phase_next = PHASE_DIGITS;
                            end
                            else
                            begin
                                // No digits reads as zero
                                if (eval_warn(pending_reg, '0, 1'b0, age_level_reg,
                                              letter_level_reg, kids_level_reg))
                                    warning_seen_next = 1'b1;
                                check_phase_next = PHASE_IDLE;
                                pending_next     = KIND_NONE;
                                value_acc_next   = '0;
                                value_neg_next   = 1'b0;
                            end
                        end
                        PHASE_DIGITS:
                        begin
                            if (digit)
                                value_acc_next = acc_digit(value_acc_reg, text_byte);
                            else
                            begin
                                if (eval_warn(pending_reg, value_acc_reg, value_neg_reg,
                                              age_level_reg, letter_level_reg,
                                              kids_level_reg))
                                    warning_seen_next = 1'b1;
                                check_phase_next = PHASE_IDLE;
                                pending_next     = KIND_NONE;
                                value_acc_next   = '0;
                                value_neg_next   = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    // Label matcher
                    if (label_length_reg != '0)
                    begin
                        if (cand_next.age)
                        begin
                            if (p < AGE_LEN)
                            begin
                                if (text_byte != age_char(p))
                                    cand_next.age = 1'b0;
                            end
                            else
                            begin
                                if (text_byte == "0")
                                begin
                                    pending_next.age = 1'b1;
                                    if (check_phase_next == PHASE_IDLE)
                                        check_phase_next = PHASE_SKIP_WORD;
                                end
                                else
                                    warning_seen_next = 1'b1;
                                cand_next.age = 1'b0;
                            end
                        end
                        if (cand_next.letter)
                        begin
                            if (ws)
                            begin
                                pending_next.letter = 1'b1;
                                if (check_phase_next == PHASE_IDLE
                                    || check_phase_next == PHASE_SKIP_WORD)
                                    check_phase_next = PHASE_SKIP_SPACE;
                            end
                            cand_next.letter = 1'b0;
                        end
                        if (cand_next.kids)
                        begin
                            if (p == 3'd1)
                            begin
                                if (text_byte != "z" && text_byte != "Z")
                                    cand_next.kids = 1'b0;
                            end
                            else
                            begin
                                if (ws)
                                begin
                                    pending_next.kids = 1'b1;
                                    if (check_phase_next == PHASE_IDLE
                                        || check_phase_next == PHASE_SKIP_WORD)
                                        check_phase_next = PHASE_SKIP_SPACE;
                                end
                                cand_next.kids = 1'b0;
                            end
                        end
                        label_length_next = (cand_next != KIND_NONE) ? p + 3'd1 : '0;
                    end

                    // Tokenizer
                    case (token_state_reg)
                        TOK_FIRST:
                        begin
                            if (!ws)
                                token_state_next = (text_byte == "\"") ? TOK_QUOTED
                                                 : (text_byte == "(")  ? TOK_RATING_START
                                                 : TOK_WORD;
                        end
                        TOK_WORD:
                        begin
                            if (ws)
                                token_state_next = TOK_FIRST;
                        end
                        TOK_QUOTED:
                        begin
                            if (text_byte == "\"")
                                token_state_next = TOK_FIRST;
                        end
                        TOK_RATING_START:
                        begin
                            if (!ws)
                            begin
                                // First byte of a label opens the candidates
                                cand_next.age     = (text_byte == "S");
                                cand_next.letter  = is_letter_label(text_byte);
                                cand_next.kids    = is_kids_first(text_byte);
                                label_length_next = (cand_next != KIND_NONE) ? 3'd1 : 3'd0;
                                token_state_next  = TOK_RATING;
                            end
                        end
                        TOK_RATING:
                        begin
                            if (ws)
                                token_state_next = TOK_VALUE_START;
                            else if (text_byte == "(")
                                token_state_next = TOK_MULTI;
                        end
                        TOK_VALUE_START:
                        begin
                            if (!ws)
                                token_state_next = TOK_VALUE;
                        end
                        TOK_VALUE:
                        begin
                            if (ws)
                                token_state_next = TOK_RATING_START;
                        end
                        TOK_MULTI:
                        begin
                            if (text_byte == ")")
                                token_state_next = TOK_RATING_START;
                        end
                        default:
                        begin
                            token_state_next = TOK_FIRST;
                        end
                    endcase
                end
            end

            if (end_of_text)
            begin
                // Final byte: close out any open label or value, then report
                if (prefix_failed_next || prefix_position_next < PREFIX_LEN)
                    verdict_next = VERDICT_NONE;
                else
                begin
                    if (!text_stopped_next
                        && ((cand_next.age && label_length_next == AGE_LEN)
                            || (check_phase_next == PHASE_DIGITS
                                && eval_warn(pending_next, value_acc_next, value_neg_next,
                                             age_level_reg, letter_level_reg,
                                             kids_level_reg))))
                        warning_seen_next = 1'b1;
                    verdict_next = warning_seen_next ? VERDICT_WARN : VERDICT_OK;
                end
                out_valid_next       = 1'b1;
                prefix_position_next = '0;
                prefix_failed_next   = 1'b0;
                token_state_next     = TOK_FIRST;
                label_length_next    = '0;
                cand_next            = KIND_NONE;
                check_phase_next     = PHASE_IDLE;
                pending_next         = KIND_NONE;
                value_acc_next       = '0;
                value_neg_next       = 1'b0;
                warning_seen_next    = 1'b0;
                text_stopped_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_position_reg <= '0;
            prefix_failed_reg   <= 1'b0;
            token_state_reg     <= TOK_FIRST;
            label_length_reg    <= '0;
            cand_reg            <= KIND_NONE;
            check_phase_reg     <= PHASE_IDLE;
            pending_reg         <= KIND_NONE;
            value_acc_reg       <= '0;
            value_neg_reg       <= 1'b0;
            warning_seen_reg    <= 1'b0;
            text_stopped_reg    <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            prefix_position_reg <= prefix_position_next;
            prefix_failed_reg   <= prefix_failed_next;
            token_state_reg     <= token_state_next;
            label_length_reg    <= label_length_next;
            cand_reg            <= cand_next;
            check_phase_reg     <= check_phase_next;
            pending_reg         <= pending_next;
            value_acc_reg       <= value_acc_next;
            value_neg_reg       <= value_neg_next;
            warning_seen_reg    <= warning_seen_next;
            text_stopped_reg    <= text_stopped_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // Verdict payload needs no reset
    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
    end

    // A live candidate always has a nonzero length, and the reverse
    a_len_matches_cand: assert property (@(posedge clk) disable iff (!rst_n)
        (cand_reg == KIND_NONE) == (label_length_reg == '0))
        else $error("label length and candidate set disagree");

    // Prefix counter never passes the prefix length
    a_prefix_bound: assert property (@(posedge clk) disable iff (!rst_n)
        prefix_position_reg <= PREFIX_LEN)
        else $error("prefix position out of range");

    // A failed prefix leaves the value checker untouched
    a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        prefix_failed_reg |-> (check_phase_reg == PHASE_IDLE && pending_reg == KIND_NONE))
        else $error("checker active after prefix failure");

    // Final byte yields a verdict next cycle and a fresh session
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && end_of_text) |=> (out_valid_reg && prefix_position_reg == '0
                                      && !warning_seen_reg && !text_stopped_reg))
        else $error("final byte did not close the session");

endmodule
